@@ rtl/core/tgf_pkg.sv @@
// Shared types and constants of the tone generator with fade.
package tgf_pkg;

    localparam int STEP_W   = 32;  // phase_step register
    localparam int COUNT_W  = 24;  // sample_count register
    localparam int FADE_W   = 16;  // fade_len register
    localparam int AMP_W    = 15;  // amplitude register
    localparam int SAMPLE_W = 16;  // output sample
    localparam int MAG_W    = 15;  // magnitude of the scaled tone
    localparam int PROD_W   = MAG_W + FADE_W;     // fade product and dividend
    localparam int DIV_STEPS = PROD_W;            // one quotient bit per cycle
    localparam int CNT_W    = $clog2(DIV_STEPS);
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    typedef enum logic [1:0] {
        REG_PHASE_STEP   = 2'd0,
        REG_SAMPLE_COUNT = 2'd1,
        REG_FADE_LEN     = 2'd2,
        REG_AMPLITUDE    = 2'd3
    } t_reg_addr;

    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [COUNT_W-1:0] sample_count;
        logic [FADE_W-1:0]  fade_len;
        logic [AMP_W-1:0]   amplitude;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic mul_tone;
        logic mul_fade;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic active;
        logic fade;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/tgf_regs.sv @@
// APB configuration registers of the tone generator.
module tgf_regs
    import tgf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    t_cfg      r_cfg;
    t_reg_addr w_addr;
    logic      w_wr;

    assign w_addr = t_reg_addr'(i_paddr[3:2]);
    assign w_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= STEP_W'(268435456);
            r_cfg.sample_count <= COUNT_W'(2400);
            r_cfg.fade_len     <= FADE_W'(160);
            r_cfg.amplitude    <= AMP_W'(20000);
        end else if (w_wr) begin
            case (w_addr)
                REG_PHASE_STEP:   r_cfg.phase_step   <= i_pwdata[STEP_W-1:0];
                REG_SAMPLE_COUNT: r_cfg.sample_count <= i_pwdata[COUNT_W-1:0];
                REG_FADE_LEN:     r_cfg.fade_len     <= i_pwdata[FADE_W-1:0];
                REG_AMPLITUDE:    r_cfg.amplitude    <= i_pwdata[AMP_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_addr)
            REG_PHASE_STEP:   o_prdata = APB_DW'(r_cfg.phase_step);
            REG_SAMPLE_COUNT: o_prdata = APB_DW'(r_cfg.sample_count);
            REG_FADE_LEN:     o_prdata = APB_DW'(r_cfg.fade_len);
            REG_AMPLITUDE:    o_prdata = APB_DW'(r_cfg.amplitude);
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/tgf_ctrl.sv @@
// Sequencer for one tick: ROM read, tone scale, fade multiply, serial divide, output load.
module tgf_ctrl
    import tgf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ROM  = 6'b000010,
        S_MUL1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) n_state = S_ROM;
            end
            S_ROM: begin
                n_state = i_sts.active ? S_MUL1 : S_DONE;
            end
            S_MUL1: begin
                o_cmd.mul_tone = 1'b1;
                n_state = i_sts.fade ? S_MUL2 : S_DONE;
            end
            S_MUL2: begin
                o_cmd.mul_fade = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_ROM)
        else $error("accepted transfer did not start the sequence");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div_cnt < CNT_W'(DIV_STEPS))
        else $error("divide counter out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("output register loaded while occupied");

endmodule

@@ rtl/core/tgf_dp.sv @@
// Datapath: phase and index state, sine ROM, shared multiplier, serial divider, output register.
module tgf_dp
    import tgf_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_WIDTH      = 32,
    parameter int INDEX_WIDTH      = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_restart,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [SAMPLE_W-1:0] o_m_tdata,
    output logic                o_m_tlast,
    output logic                o_m_tuser
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int CMP_W  = ((INDEX_WIDTH > COUNT_W) ? INDEX_WIDTH : COUNT_W) + 1;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // 32767 * sin(m / depth * pi / 2), Q30 Taylor series, rounded
    function automatic logic [SAMPLE_W-1:0] f_quarter(input longint unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        x    = m * HALF_PI_Q30 / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        if (sum < 0) sum = 0;
        v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] f_entry(input longint unsigned k);
        longint unsigned n;
        longint unsigned quad;
        longint unsigned r;
        logic [SAMPLE_W-1:0] v;
        n    = 64'd4 * k;
        quad = n / SINE_TABLE_DEPTH;
        r    = n % SINE_TABLE_DEPTH;
        v    = quad[0] ? f_quarter(SINE_TABLE_DEPTH - r) : f_quarter(r);
        return (quad >= 64'd2) ? -v : v;
    endfunction

    logic signed [SAMPLE_W-1:0] w_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        assign w_rom[k] = f_entry(k);
    end

    // run state
    logic [INDEX_WIDTH-1:0] r_index;
    logic [PHASE_WIDTH-1:0] r_phase;

    // per-tick work registers
    logic [ADDR_W-1:0]          r_addr;
    logic signed [SAMPLE_W-1:0] r_entry;
    logic                       r_active;
    logic                       r_fade;
    logic                       r_last;
    logic [FADE_W-1:0]          r_num;
    logic [PROD_W-1:0]          r_prod;
    logic [FADE_W-1:0]          r_rem;

    // output register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_last;
    logic                r_out_active;

    // tick decode from the effective index
    logic [INDEX_WIDTH-1:0] w_idx;
    logic [PHASE_WIDTH-1:0] w_phase;
    logic [CMP_W-1:0]       w_i, w_cnt, w_fade, w_left;
    logic                   w_active, w_in, w_out, w_last;

    assign w_idx   = i_restart ? '0 : r_index;
    assign w_phase = i_restart ? '0 : r_phase;
    assign w_i     = CMP_W'(w_idx);
    assign w_cnt   = CMP_W'(i_cfg.sample_count);
    assign w_fade  = CMP_W'(i_cfg.fade_len);
    assign w_left  = w_cnt - w_i;
    assign w_active = w_i < w_cnt;
    assign w_last   = (w_left == CMP_W'(1));
    assign w_in     = w_i < w_fade;
    // fade out is skipped on a run shorter than the fade
    assign w_out    = (w_cnt >= w_fade) && (w_i > w_cnt - w_fade);

    // shared multiplier
    logic [MAG_W-1:0]    w_entry_mag;
    logic [SAMPLE_W-1:0] w_entry_abs;
    logic [MAG_W-1:0]    w_ma;
    logic [FADE_W-1:0]   w_mb;
    logic [PROD_W-1:0]   w_mul;

    assign w_entry_abs = r_entry[SAMPLE_W-1] ? -r_entry : r_entry;
    assign w_entry_mag = w_entry_abs[MAG_W-1:0];
    assign w_ma  = i_cmd.mul_tone ? w_entry_mag : r_prod[2*MAG_W-1:MAG_W];
    assign w_mb  = i_cmd.mul_tone ? FADE_W'(i_cfg.amplitude) : r_num;
    assign w_mul = PROD_W'(w_ma) * PROD_W'(w_mb);

    // restoring divide step
    logic [FADE_W:0] w_trial;
    logic            w_qbit;

    assign w_trial = {r_rem, r_prod[PROD_W-1]};
    assign w_qbit  = w_trial >= {1'b0, i_cfg.fade_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_phase <= '0;
        end else if (i_cmd.accept) begin
            r_index <= w_active ? INDEX_WIDTH'(w_idx + 1'b1) : w_idx;
            r_phase <= w_active ? w_phase + PHASE_WIDTH'(i_cfg.phase_step) : w_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= w_rom[r_addr];
        if (i_cmd.accept) begin
            r_addr   <= w_phase[PHASE_WIDTH-1 -: ADDR_W];
            r_active <= w_active;
            r_last   <= w_active && w_last;
            r_fade   <= w_active && (i_cfg.fade_len != '0) && (w_in || w_out);
            r_num    <= w_in ? w_i[FADE_W-1:0] : w_left[FADE_W-1:0];
        end
        if (i_cmd.mul_tone || i_cmd.mul_fade) begin
            r_prod <= w_mul;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_prod <= {r_prod[PROD_W-2:0], w_qbit};
            r_rem  <= w_qbit ? FADE_W'(w_trial - {1'b0, i_cfg.fade_len})
                             : w_trial[FADE_W-1:0];
        end
    end

    // final magnitude: quotient after a fade, else tone product >> 15
    logic [MAG_W-1:0]    w_mag;
    logic [SAMPLE_W-1:0] w_mag_ext;
    logic [SAMPLE_W-1:0] w_sample;

    assign w_mag     = r_fade ? r_prod[MAG_W-1:0] : r_prod[2*MAG_W-1:MAG_W];
    assign w_mag_ext = SAMPLE_W'(w_mag);
    assign w_sample  = !r_active ? '0 : (r_entry[SAMPLE_W-1] ? -w_mag_ext : w_mag_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_sample <= w_sample;
            r_out_last   <= r_last;
            r_out_active <= r_active;
        end
    end

    assign o_sts.active   = r_active;
    assign o_sts.fade     = r_fade;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sample;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_active;

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0 && !o_m_tlast)
        else $error("inactive sample not zero");

    a_fade_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_fade |-> r_active && r_fade)
        else $error("fade multiply on an inactive or unfaded tick");

endmodule

@@ rtl/core/tone_generator_with_fade.sv @@
// Top level of the sine tone generator with linear fade in and fade out.
//
// Usage:
//   Slave stream (i_s_*): one transfer per sample tick; i_s_tdata bit 0 is
//   restart, which begins a new beep at index zero and phase zero.
//   Master stream (o_m_*): one transfer per tick; tdata is the signed
//   sample, tlast marks the final sample of the beep, tuser is active.
//   After the beep ends, ticks give zero with tuser low until a restart.
//   APB port: phase_step 0x0, sample_count 0x4, fade_len 0x8, amplitude 0xC.
// Sequence:
//   A tick passes the states ROM, MUL1 and DONE outside the fade regions,
//   ROM and DONE on an inactive tick, and ROM, MUL1, MUL2, the 31-step
//   serial divide by fade_len and DONE inside the fade regions. One tick
//   is in work at a time; tready returns the cycle after the result is
//   loaded.
// Reset: index and phase clear, registers take their default values.
// Stall: a result waits in the output register while i_m_tready is low;
//   the next tick is processed and holds until that register frees.
module tone_generator_with_fade
    import tgf_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_WIDTH      = 32,
    parameter int INDEX_WIDTH      = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // [0] restart, [7:1] zero
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [SAMPLE_W-1:0] o_m_tdata,   // [15:0] sample
    output logic                o_m_tlast,
    output logic                o_m_tuser,   // [0] active
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign pready = 1'b1;

    tgf_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    tgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tgf_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_WIDTH      (PHASE_WIDTH),
        .INDEX_WIDTH      (INDEX_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_restart  (i_s_tdata[0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
